@@ design/wcsm_pkg.sv @@
// Shared types and constants for the wall centering straight move block.
// Used by the serial arithmetic units, the top level and the testbench.
package wcsm_pkg;

  localparam int HALF_BLOCK_DISTANCE = 90;
  localparam int FULL_BLOCK_DISTANCE = 180;
  localparam int AXIS_STEP = 720;
  localparam int HALF_TURN = 2880;
  localparam int FULL_TURN = 5760;
  localparam int ERR_LIMIT = 8;
  localparam int CREEP_DRIVE = 20;
  localparam int DEFAULT_TICK_US = 1000;
  localparam int DRIVE_LIMIT = 1023;
  localparam int DERIV_SCALE = 1000000;

  localparam int MUL_W = 25;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIV_N_W = 50;
  localparam int DIV_D_W = 25;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);
  localparam int CORR_W = 52;

  typedef enum logic [2:0] {
    REG_BASE_RUN = 3'd0,
    REG_BASE_SPEED = 3'd1,
    REG_GAIN_P = 3'd2,
    REG_GAIN_TD = 3'd3,
    REG_GAIN_H = 3'd4,
    REG_FRONT_STOP = 3'd5,
    REG_WALL_THRESH = 3'd6,
    REG_TARGET_WALL = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    CAUSE_NONE = 2'd0,
    CAUSE_TIME = 2'd1,
    CAUSE_FRONT = 2'd2
  } stop_cause_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SNAP,
    S_RUN_DIV,
    S_MUL_SPD,
    S_DIV_SPD,
    S_MUL_KT,
    S_MUL_DF,
    S_MUL_DN,
    S_DIV_DN,
    S_MUL_P,
    S_MUL_H,
    S_DRV_L,
    S_DRV_R,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic [PROD_W-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_N_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ design/wcsm_if.sv @@
// Valid/ready channel interfaces for the input items and result items.
// Depends on nothing but plain logic types.
interface wcsm_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic [9:0] move_distance;
  logic [7:0] left_side_distance;
  logic [7:0] right_side_distance;
  logic [11:0] front_distance;
  logic [12:0] heading;
  logic [19:0] tick_us;
  modport source(output valid, mode, move_distance, left_side_distance,
                 right_side_distance, front_distance, heading, tick_us, input ready);
  modport sink(input valid, mode, move_distance, left_side_distance,
               right_side_distance, front_distance, heading, tick_us, output ready);
endinterface

interface wcsm_out_if;
  logic valid;
  logic ready;
  logic signed [10:0] left_drive;
  logic signed [10:0] right_drive;
  logic moving;
  logic [1:0] stop_cause;
  modport source(output valid, left_drive, right_drive, moving, stop_cause, input ready);
  modport sink(input valid, left_drive, right_drive, moving, stop_cause, output ready);
endinterface

@@ design/wall_centering_straight_move.sv @@
// Straight move controller with PD wall centering and heading hold.
// A start item for a half block takes a serial divide by 100; a control tick takes up to
// two serial divides and a chain of shift-add multiplies.
// One item is in work at a time; the next can be taken from the cycle after a result is loaded,
// and that result waits in the output register. Reset is synchronous and restores defaults.
module wall_centering_straight_move #(
  parameter int HALF_BLOCK_DISTANCE = wcsm_pkg::HALF_BLOCK_DISTANCE
) (
  input  logic clk,
  input  logic rst_n,
  wcsm_in_if.sink in_chan,
  wcsm_out_if.source out_chan,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int CW = wcsm_pkg::CORR_W;

  function automatic logic signed [14:0] wrap_diff(input logic [2:0] k,
                                                   input logic [12:0] h);
    logic signed [14:0] a;
    a = $signed(15'(k) * 15'(wcsm_pkg::AXIS_STEP)) - $signed({2'b00, h});
    if (a > 15'sd2880) a = a - 15'sd5760;
    if (a < -15'sd2880) a = a + 15'sd5760;
    return a;
  endfunction

  function automatic logic signed [10:0] to_drive(input logic signed [CW-1:0] v);
    logic [CW-1:0] mag;
    logic [CW-13:0] q;
    logic [10:0] lim;
    mag = v[CW-1] ? CW'(-v) : CW'(v);
    q = mag[CW-1:12];
    lim = (q > (CW-12)'(wcsm_pkg::DRIVE_LIMIT)) ? 11'(wcsm_pkg::DRIVE_LIMIT) : q[10:0];
    return v[CW-1] ? $signed(-lim) : $signed(lim);
  endfunction

  logic [19:0] base_run_r;
  logic [7:0] base_speed_r, wth_r, tgt_r;
  logic [11:0] km_r, td_r, ka_r, fsd_r;

  logic signed [4:0] held_r, prev_r;
  logic [23:0] speed_r;
  logic [20:0] elapsed_r;
  logic [19:0] run_r;
  logic [2:0] axis_r;
  logic running_r, full_r, half_r;

  logic [12:0] head_r;
  logic [19:0] dt_r;
  logic signed [5:0] diff_r;
  logic signed [14:0] ang_r;
  logic [23:0] kt_r;
  logic [24:0] dmag_r;
  logic signed [CW-1:0] corr_r;
  logic [2:0] k_r, best_r;
  logic [11:0] best_mag_r;
  logic issued_r;

  logic signed [10:0] res_l_r, res_rr;
  logic res_mv_r;
  logic [1:0] res_cause_r;
  logic out_valid_r;
  logic signed [10:0] out_l_r, out_rt_r;
  logic out_mv_r;
  logic [1:0] out_cause_r;

  wcsm_pkg::state_t state_r, state_nxt;
  wcsm_pkg::mul_req_t mul_req;
  wcsm_pkg::mul_rsp_t mul_rsp;
  wcsm_pkg::div_req_t div_req;
  wcsm_pkg::div_rsp_t div_rsp;

  logic in_ready, accept, load_out;
  logic lw, rw;
  logic signed [9:0] e_raw;
  logic signed [4:0] err_new;
  logic [19:0] dt_in;
  logic [21:0] e_sum;
  logic [20:0] limit;
  logic stop_time, stop_front;
  logic signed [14:0] snap_d;
  logic [11:0] snap_mag;
  logic snap_take;
  logic [25:0] half_num;
  logic [4:0] diff_mag;
  logic [3:0] held_mag;
  logic [11:0] ang_mag;
  logic signed [CW-1:0] p_ext, sp_ext;

  wcsm_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  wcsm_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign accept = in_chan.valid && in_ready;
  assign load_out = (state_r == wcsm_pkg::S_OUT) && (!out_valid_r || out_chan.ready);

  always_comb begin
    lw = in_chan.left_side_distance < wth_r;
    rw = in_chan.right_side_distance < wth_r;
    if (lw && rw) begin
      e_raw = $signed({2'b00, in_chan.right_side_distance})
            - $signed({2'b00, in_chan.left_side_distance});
    end else if (lw) begin
      e_raw = $signed({2'b00, tgt_r}) - $signed({2'b00, in_chan.left_side_distance});
    end else if (rw) begin
      e_raw = $signed({2'b00, in_chan.right_side_distance}) - $signed({2'b00, tgt_r});
    end else begin
      e_raw = 10'(held_r);
    end
    if (e_raw > 10'sd8) begin
      err_new = 5'sd8;
    end else if (e_raw < -10'sd8) begin
      err_new = -5'sd8;
    end else begin
      err_new = e_raw[4:0];
    end
  end

  assign dt_in = (in_chan.tick_us == '0) ? 20'(wcsm_pkg::DEFAULT_TICK_US) : in_chan.tick_us;
  assign e_sum = 22'(elapsed_r) + 22'(dt_in);
  assign limit = {run_r, 1'b0};
  assign stop_time = elapsed_r >= limit;
  assign stop_front = in_chan.front_distance < fsd_r;

  assign snap_d = wrap_diff(k_r, head_r);
  assign snap_mag = snap_d[14] ? 12'(-snap_d) : snap_d[11:0];
  assign snap_take = (k_r == '0) || (snap_mag < best_mag_r);
  assign half_num = {1'b0, base_run_r, 5'b0} + {5'b0, base_run_r, 1'b0}
                  + {6'b0, base_run_r} + 26'd50;

  assign diff_mag = diff_r[5] ? 5'(-diff_r) : diff_r[4:0];
  assign held_mag = held_r[4] ? 4'(-held_r) : held_r[3:0];
  assign ang_mag = ang_r[14] ? 12'(-ang_r) : ang_r[11:0];
  assign p_ext = $signed({{(CW-wcsm_pkg::PROD_W){1'b0}}, mul_rsp.p});
  assign sp_ext = $signed({{(CW-20){1'b0}}, speed_r[23:4]});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wcsm_pkg::S_IDLE: begin
        if (accept) begin
          if (!in_chan.mode) begin
            state_nxt = wcsm_pkg::S_SNAP;
          end else if (!running_r || stop_time || stop_front) begin
            state_nxt = wcsm_pkg::S_OUT;
          end else begin
            state_nxt = wcsm_pkg::S_MUL_SPD;
          end
        end
      end
      wcsm_pkg::S_SNAP: begin
        if (k_r == 3'd7) begin
          state_nxt = half_r ? wcsm_pkg::S_RUN_DIV : wcsm_pkg::S_OUT;
        end
      end
      wcsm_pkg::S_RUN_DIV: if (div_rsp.done) state_nxt = wcsm_pkg::S_OUT;
      wcsm_pkg::S_MUL_SPD: begin
        if (run_r == '0) begin
          state_nxt = wcsm_pkg::S_MUL_KT;
        end else if (mul_rsp.done) begin
          state_nxt = wcsm_pkg::S_DIV_SPD;
        end
      end
      wcsm_pkg::S_DIV_SPD: if (div_rsp.done) state_nxt = wcsm_pkg::S_MUL_KT;
      wcsm_pkg::S_MUL_KT: if (mul_rsp.done) state_nxt = wcsm_pkg::S_MUL_DF;
      wcsm_pkg::S_MUL_DF: if (mul_rsp.done) state_nxt = wcsm_pkg::S_MUL_DN;
      wcsm_pkg::S_MUL_DN: if (mul_rsp.done) state_nxt = wcsm_pkg::S_DIV_DN;
      wcsm_pkg::S_DIV_DN: if (div_rsp.done) state_nxt = wcsm_pkg::S_MUL_P;
      wcsm_pkg::S_MUL_P: if (mul_rsp.done) state_nxt = wcsm_pkg::S_MUL_H;
      wcsm_pkg::S_MUL_H: if (mul_rsp.done) state_nxt = wcsm_pkg::S_DRV_L;
      wcsm_pkg::S_DRV_L: state_nxt = wcsm_pkg::S_DRV_R;
      wcsm_pkg::S_DRV_R: state_nxt = wcsm_pkg::S_OUT;
      wcsm_pkg::S_OUT: if (load_out) state_nxt = wcsm_pkg::S_IDLE;
      default: state_nxt = wcsm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == wcsm_pkg::S_IDLE);
    mul_req = '0;
    div_req = '0;
    case (state_r)
      wcsm_pkg::S_RUN_DIV: begin
        div_req.start = !issued_r;
        div_req.num = wcsm_pkg::DIV_N_W'(half_num);
        div_req.den = wcsm_pkg::DIV_D_W'(100);
      end
      wcsm_pkg::S_MUL_SPD: begin
        mul_req.start = !issued_r && (run_r != '0);
        mul_req.a = wcsm_pkg::MUL_W'(dt_r);
        mul_req.b = wcsm_pkg::MUL_W'(base_speed_r);
      end
      wcsm_pkg::S_DIV_SPD: begin
        div_req.start = !issued_r;
        div_req.num = {6'b0, mul_rsp.p[27:0], 16'b0};
        div_req.den = wcsm_pkg::DIV_D_W'(limit);
      end
      wcsm_pkg::S_MUL_KT: begin
        mul_req.start = !issued_r;
        mul_req.a = wcsm_pkg::MUL_W'(km_r);
        mul_req.b = wcsm_pkg::MUL_W'(td_r);
      end
      wcsm_pkg::S_MUL_DF: begin
        mul_req.start = !issued_r;
        mul_req.a = wcsm_pkg::MUL_W'(wcsm_pkg::DERIV_SCALE);
        mul_req.b = wcsm_pkg::MUL_W'(diff_mag);
      end
      wcsm_pkg::S_MUL_DN: begin
        mul_req.start = !issued_r;
        mul_req.a = dmag_r;
        mul_req.b = wcsm_pkg::MUL_W'(kt_r);
      end
      wcsm_pkg::S_DIV_DN: begin
        div_req.start = !issued_r;
        div_req.num = wcsm_pkg::DIV_N_W'(mul_rsp.p);
        div_req.den = {1'b0, dt_r, 4'b0};
      end
      wcsm_pkg::S_MUL_P: begin
        mul_req.start = !issued_r;
        mul_req.a = wcsm_pkg::MUL_W'(km_r);
        mul_req.b = wcsm_pkg::MUL_W'(held_mag);
      end
      wcsm_pkg::S_MUL_H: begin
        mul_req.start = !issued_r;
        mul_req.a = wcsm_pkg::MUL_W'(ka_r);
        mul_req.b = wcsm_pkg::MUL_W'(ang_mag);
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wcsm_pkg::S_IDLE;
      issued_r <= 1'b0;
      out_valid_r <= 1'b0;
      base_run_r <= 20'd350000;
      base_speed_r <= 8'd100;
      km_r <= 12'd192;
      td_r <= 12'd102;
      ka_r <= 12'd64;
      fsd_r <= 12'd60;
      wth_r <= 8'd8;
      tgt_r <= 8'd4;
      held_r <= '0;
      prev_r <= '0;
      speed_r <= '0;
      elapsed_r <= '0;
      run_r <= '0;
      axis_r <= '0;
      running_r <= 1'b0;
      full_r <= 1'b0;
      half_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mul_req.start || div_req.start) begin
        issued_r <= 1'b1;
      end else if (mul_rsp.done || div_rsp.done) begin
        issued_r <= 1'b0;
      end

      if (cfg_we) begin
        case (wcsm_pkg::reg_index_t'(cfg_index))
          wcsm_pkg::REG_BASE_RUN: base_run_r <= cfg_data;
          wcsm_pkg::REG_BASE_SPEED: base_speed_r <= cfg_data[7:0];
          wcsm_pkg::REG_GAIN_P: km_r <= cfg_data[11:0];
          wcsm_pkg::REG_GAIN_TD: td_r <= cfg_data[11:0];
          wcsm_pkg::REG_GAIN_H: ka_r <= cfg_data[11:0];
          wcsm_pkg::REG_FRONT_STOP: fsd_r <= cfg_data[11:0];
          wcsm_pkg::REG_WALL_THRESH: wth_r <= cfg_data[7:0];
          wcsm_pkg::REG_TARGET_WALL: tgt_r <= cfg_data[7:0];
          default: base_run_r <= base_run_r;
        endcase
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        wcsm_pkg::S_IDLE: begin
          if (accept && !in_chan.mode) begin
            held_r <= err_new;
            prev_r <= err_new;
            full_r <= in_chan.move_distance == 10'(wcsm_pkg::FULL_BLOCK_DISTANCE);
            half_r <= in_chan.move_distance == 10'(HALF_BLOCK_DISTANCE);
            run_r <= base_run_r;
            speed_r <= {base_speed_r, 16'b0};
            elapsed_r <= '0;
            running_r <= 1'b1;
          end else if (accept && running_r && (stop_time || stop_front)) begin
            running_r <= 1'b0;
          end else if (accept && running_r) begin
            elapsed_r <= e_sum[21] ? '1 : e_sum[20:0];
            held_r <= err_new;
            prev_r <= err_new;
          end
        end
        wcsm_pkg::S_SNAP: begin
          if (k_r == 3'd7) begin
            axis_r <= snap_take ? k_r : best_r;
          end
        end
        wcsm_pkg::S_RUN_DIV: begin
          if (div_rsp.done) run_r <= div_rsp.quo[19:0];
        end
        wcsm_pkg::S_MUL_SPD: begin
          if (run_r == '0) speed_r <= '0;
        end
        wcsm_pkg::S_DIV_SPD: begin
          if (div_rsp.done) begin
            if (wcsm_pkg::DIV_N_W'(speed_r) > div_rsp.quo) begin
              speed_r <= speed_r - div_rsp.quo[23:0];
            end else begin
              speed_r <= '0;
            end
          end
        end
        default: begin
          speed_r <= speed_r;
        end
      endcase
    end

    if (accept) begin
      head_r <= in_chan.heading;
      dt_r <= dt_in;
      diff_r <= 6'(err_new) - 6'(prev_r);
      ang_r <= wrap_diff(axis_r, in_chan.heading);
      k_r <= '0;
      res_l_r <= '0;
      res_rr <= '0;
      res_mv_r <= 1'b0;
      res_cause_r <= wcsm_pkg::CAUSE_NONE;
      if (!in_chan.mode) begin
        res_mv_r <= 1'b1;
      end else if (running_r && (stop_time || stop_front)) begin
        res_cause_r <= stop_time ? wcsm_pkg::CAUSE_TIME : wcsm_pkg::CAUSE_FRONT;
        if (full_r) begin
          res_l_r <= 11'(wcsm_pkg::CREEP_DRIVE);
          res_rr <= 11'(wcsm_pkg::CREEP_DRIVE);
        end
      end else if (running_r) begin
        res_mv_r <= 1'b1;
      end
    end

    if (state_r == wcsm_pkg::S_SNAP) begin
      k_r <= k_r + 1'b1;
      if (snap_take) begin
        best_r <= k_r;
        best_mag_r <= snap_mag;
      end
    end
    if ((state_r == wcsm_pkg::S_MUL_KT) && mul_rsp.done) kt_r <= mul_rsp.p[23:0];
    if ((state_r == wcsm_pkg::S_MUL_DF) && mul_rsp.done) dmag_r <= mul_rsp.p[24:0];
    if ((state_r == wcsm_pkg::S_DIV_DN) && div_rsp.done) begin
      corr_r <= diff_r[5] ? -$signed(CW'(div_rsp.quo)) : $signed(CW'(div_rsp.quo));
    end
    if ((state_r == wcsm_pkg::S_MUL_P) && mul_rsp.done) begin
      corr_r <= held_r[4] ? corr_r - (p_ext <<< 4) : corr_r + (p_ext <<< 4);
    end
    if ((state_r == wcsm_pkg::S_MUL_H) && mul_rsp.done) begin
      corr_r <= ang_r[14] ? corr_r - p_ext : corr_r + p_ext;
    end
    if (state_r == wcsm_pkg::S_DRV_L) res_l_r <= to_drive(sp_ext + corr_r);
    if (state_r == wcsm_pkg::S_DRV_R) res_rr <= to_drive(sp_ext - corr_r);

    if (load_out) begin
      out_l_r <= res_l_r;
      out_rt_r <= res_rr;
      out_mv_r <= res_mv_r;
      out_cause_r <= res_cause_r;
    end
  end

  assign in_chan.ready = in_ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.left_drive = out_l_r;
  assign out_chan.right_drive = out_rt_r;
  assign out_chan.moving = out_mv_r;
  assign out_chan.stop_cause = out_cause_r;

endmodule

@@ design/wcsm_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on wcsm_pkg for widths and request/response structs.
module wcsm_mul (
  input  logic clk,
  input  logic rst_n,
  input  wcsm_pkg::mul_req_t req,
  output wcsm_pkg::mul_rsp_t rsp
);

  logic [wcsm_pkg::PROD_W-1:0] a_r, a_nxt;
  logic [wcsm_pkg::MUL_W-1:0] b_r, b_nxt;
  logic [wcsm_pkg::PROD_W-1:0] p_r, p_nxt;
  logic busy_r, busy_nxt;
  logic done;

  assign done = busy_r && (b_r == '0);

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    p_nxt = p_r;
    busy_nxt = busy_r;
    if (req.start) begin
      a_nxt = wcsm_pkg::PROD_W'(req.a);
      b_nxt = req.b;
      p_nxt = '0;
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        p_nxt = p_r + a_r;
      end
      a_nxt = a_r << 1;
      b_nxt = b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign rsp.done = done;
  assign rsp.p = p_r;

endmodule

@@ design/wcsm_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on wcsm_pkg for widths and request/response structs.
module wcsm_div (
  input  logic clk,
  input  logic rst_n,
  input  wcsm_pkg::div_req_t req,
  output wcsm_pkg::div_rsp_t rsp
);

  logic [wcsm_pkg::DIV_N_W-1:0] q_r, q_nxt;
  logic [wcsm_pkg::DIV_D_W-1:0] rem_r, rem_nxt;
  logic [wcsm_pkg::DIV_D_W-1:0] den_r, den_nxt;
  logic [wcsm_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [wcsm_pkg::DIV_D_W:0] trial;
  logic fits;
  logic done;

  assign done = busy_r && (cnt_r == '0);
  assign trial = {rem_r, q_r[wcsm_pkg::DIV_N_W-1]};
  assign fits = trial >= {1'b0, den_r};

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      q_nxt = req.num;
      rem_nxt = '0;
      den_nxt = req.den;
      cnt_nxt = wcsm_pkg::DIV_CNT_W'(wcsm_pkg::DIV_N_W);
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = wcsm_pkg::DIV_D_W'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = trial[wcsm_pkg::DIV_D_W-1:0];
      end
      q_nxt = {q_r[wcsm_pkg::DIV_N_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done;
  assign rsp.quo = q_r;

endmodule

@@ test/wcsm_checker.sv @@
`timescale 1ns / 100ps
// Checker for the wall centering straight move block: predicts each result
// from accepted transfers and configuration writes. Depends on wcsm_pkg.
module wcsm_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  logic in_mode,
  input  logic [9:0] in_move_distance,
  input  logic [7:0] in_left,
  input  logic [7:0] in_right,
  input  logic [11:0] in_front,
  input  logic [12:0] in_heading,
  input  logic [19:0] in_tick_us,
  input  logic out_valid,
  input  logic out_ready,
  input  logic signed [10:0] out_left,
  input  logic signed [10:0] out_right,
  input  logic out_moving,
  input  logic [1:0] out_cause,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [19:0] cfg_data,
  output int fail_count,
  output int pending,
  output int results_seen,
  output int stops_seen
);

  typedef struct packed {
    logic signed [10:0] left_drive;
    logic signed [10:0] right_drive;
    logic moving;
    wcsm_pkg::stop_cause_t cause;
  } drive_cmd_t;

  drive_cmd_t expected_cmds[$];

  logic [19:0] run_base;
  logic [7:0] speed_base, wall_thresh, target_wall;
  logic [11:0] km, td, ka, front_stop;

  int held_err, prev_err;
  longint speed_q16, elapsed, run_len;
  int axis;
  bit active, full_block;

  function automatic int wrap_heading(int a);
    if (a > wcsm_pkg::HALF_TURN) a -= wcsm_pkg::FULL_TURN;
    if (a < -wcsm_pkg::HALF_TURN) a += wcsm_pkg::FULL_TURN;
    return a;
  endfunction

  function automatic logic signed [10:0] clamp_drive(longint q12);
    longint v;
    v = q12 / 4096;
    if (v > wcsm_pkg::DRIVE_LIMIT) v = wcsm_pkg::DRIVE_LIMIT;
    if (v < -wcsm_pkg::DRIVE_LIMIT) v = -wcsm_pkg::DRIVE_LIMIT;
    return v[10:0];
  endfunction

  function automatic void track_wall(int l, int r);
    bit lw, rw;
    int e;
    lw = l < wall_thresh;
    rw = r < wall_thresh;
    e = held_err;
    if (lw && rw) e = r - l;
    else if (lw) e = int'(target_wall) - l;
    else if (rw) e = r - int'(target_wall);
    if (e > wcsm_pkg::ERR_LIMIT) e = wcsm_pkg::ERR_LIMIT;
    if (e < -wcsm_pkg::ERR_LIMIT) e = -wcsm_pkg::ERR_LIMIT;
    held_err = e;
  endfunction

  function automatic drive_cmd_t predict_move_step();
    drive_cmd_t c;
    longint dt, dec, corr, sp;
    int best, best_mag, d, m, ang;
    c = '0;
    if (!in_mode) begin
      track_wall(in_left, in_right);
      prev_err = held_err;
      full_block = in_move_distance == wcsm_pkg::FULL_BLOCK_DISTANCE;
      run_len = run_base;
      if (in_move_distance == wcsm_pkg::HALF_BLOCK_DISTANCE)
        run_len = (run_len * 35 + 50) / 100;
      speed_q16 = longint'(speed_base) << 16;
      elapsed = 0;
      best = 0;
      best_mag = 0;
      for (int k = 0; k < 8; k++) begin
        d = wrap_heading(k * wcsm_pkg::AXIS_STEP - int'(in_heading));
        m = d < 0 ? -d : d;
        if (k == 0 || m < best_mag) begin
          best = k;
          best_mag = m;
        end
      end
      axis = best;
      active = 1;
      c.moving = 1;
      return c;
    end
    if (!active) return c;
    if (elapsed >= 2 * run_len) c.cause = wcsm_pkg::CAUSE_TIME;
    else if (in_front < front_stop) c.cause = wcsm_pkg::CAUSE_FRONT;
    if (c.cause != wcsm_pkg::CAUSE_NONE) begin
      active = 0;
      c.left_drive = full_block ? 11'(wcsm_pkg::CREEP_DRIVE) : 11'sd0;
      c.right_drive = c.left_drive;
      return c;
    end
    dt = in_tick_us != 0 ? in_tick_us : wcsm_pkg::DEFAULT_TICK_US;
    elapsed = elapsed + dt;
    if (elapsed > 64'h1FFFFF) elapsed = 64'h1FFFFF;
    dec = run_len != 0 ? (longint'(speed_base) * dt * 65536) / (2 * run_len) : speed_q16;
    speed_q16 = speed_q16 > dec ? speed_q16 - dec : 0;
    track_wall(in_left, in_right);
    ang = wrap_heading(axis * wcsm_pkg::AXIS_STEP - int'(in_heading));
    corr = longint'(km) * held_err * 16
         + (longint'(km) * longint'(td) * (held_err - prev_err) * wcsm_pkg::DERIV_SCALE)
           / (dt * 16)
         + longint'(ka) * ang;
    sp = speed_q16 >>> 4;
    prev_err = held_err;
    c.left_drive = clamp_drive(sp + corr);
    c.right_drive = clamp_drive(sp - corr);
    c.moving = 1;
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    fail_count++;
  endtask

  assign pending = expected_cmds.size();

  always @(posedge clk) begin
    drive_cmd_t want;
    if (!rst_n) begin
      run_base <= 20'd350000;
      speed_base <= 8'd100;
      km <= 12'd192;
      td <= 12'd102;
      ka <= 12'd64;
      front_stop <= 12'd60;
      wall_thresh <= 8'd8;
      target_wall <= 8'd4;
      held_err = 0;
      prev_err = 0;
      speed_q16 = 0;
      elapsed = 0;
      run_len = 0;
      axis = 0;
      active = 0;
      full_block = 0;
      fail_count = 0;
      results_seen <= 0;
      stops_seen <= 0;
      expected_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (wcsm_pkg::reg_index_t'(cfg_index))
          wcsm_pkg::REG_BASE_RUN: run_base <= cfg_data;
          wcsm_pkg::REG_BASE_SPEED: speed_base <= cfg_data[7:0];
          wcsm_pkg::REG_GAIN_P: km <= cfg_data[11:0];
          wcsm_pkg::REG_GAIN_TD: td <= cfg_data[11:0];
          wcsm_pkg::REG_GAIN_H: ka <= cfg_data[11:0];
          wcsm_pkg::REG_FRONT_STOP: front_stop <= cfg_data[11:0];
          wcsm_pkg::REG_WALL_THRESH: wall_thresh <= cfg_data[7:0];
          wcsm_pkg::REG_TARGET_WALL: target_wall <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_cmds.push_back(predict_move_step());
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (out_cause != wcsm_pkg::CAUSE_NONE) stops_seen <= stops_seen + 1;
        if (expected_cmds.size() == 0) begin
          report_mismatch("result with none pending", 1, 0);
        end else begin
          want = expected_cmds.pop_front();
          if (out_left !== want.left_drive) report_mismatch("left_drive", out_left, want.left_drive);
          if (out_right !== want.right_drive)
            report_mismatch("right_drive", out_right, want.right_drive);
          if (out_moving !== want.moving) report_mismatch("moving", out_moving, want.moving);
          if (out_cause !== want.cause) report_mismatch("stop_cause", out_cause, want.cause);
        end
      end
    end
  end
endmodule

@@ test/wall_centering_straight_move_test.sv @@
`timescale 1ns / 100ps
// Top of the wall centering straight move regression: clock, reset, stimulus
// and verdict. Depends on wcsm_pkg, the channel interfaces, the design top and wcsm_checker.
module wall_centering_straight_move_test;

  localparam int QUIET_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;
  int fail_count, pending, results_seen, stops_seen;
  int quiet_cycles = 0;
  int sent = 0;
  bit hold_off = 0;
  bit stimulus_done = 0;

  wcsm_in_if in_chan ();
  wcsm_out_if out_chan ();

  always #1 clk = ~clk;

  wall_centering_straight_move u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  wcsm_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_chan.valid), .in_ready(in_chan.ready), .in_mode(in_chan.mode),
    .in_move_distance(in_chan.move_distance), .in_left(in_chan.left_side_distance),
    .in_right(in_chan.right_side_distance), .in_front(in_chan.front_distance),
    .in_heading(in_chan.heading), .in_tick_us(in_chan.tick_us),
    .out_valid(out_chan.valid), .out_ready(out_chan.ready),
    .out_left(out_chan.left_drive), .out_right(out_chan.right_drive),
    .out_moving(out_chan.moving), .out_cause(out_chan.stop_cause),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .stops_seen(stops_seen)
  );

  initial begin
    in_chan.valid = 0;
    in_chan.mode = 0;
    in_chan.move_distance = '0;
    in_chan.left_side_distance = '0;
    in_chan.right_side_distance = '0;
    in_chan.front_distance = '0;
    in_chan.heading = '0;
    in_chan.tick_us = '0;
    out_chan.ready = 0;
  end

  // The result side stalls at random, with one long hold-off during the run.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_chan.ready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      gap = (sent % 300 < 60) ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_chan.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1;
      @(posedge clk iff out_chan.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("wall_centering_straight_move regression: fail");
      $finish;
    end
  end

  task automatic send_item(logic mode, logic [9:0] move_dist, logic [7:0] l, logic [7:0] r,
                           logic [11:0] front, logic [12:0] head, logic [19:0] tick);
    int gap;
    gap = (sent % 300 < 60) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_chan.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1;
    in_chan.mode <= mode;
    in_chan.move_distance <= move_dist;
    in_chan.left_side_distance <= l;
    in_chan.right_side_distance <= r;
    in_chan.front_distance <= front;
    in_chan.heading <= head;
    in_chan.tick_us <= tick;
    @(posedge clk iff in_chan.ready);
    sent++;
  endtask

  task automatic write_reg(wcsm_pkg::reg_index_t idx, logic [19:0] value);
    in_chan.valid <= 0;
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic settle;
    in_chan.valid <= 0;
    wait (pending == 0);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_distance();
    case ($urandom_range(0, 3))
      0: return 10'(wcsm_pkg::HALF_BLOCK_DISTANCE);
      1: return 10'(wcsm_pkg::FULL_BLOCK_DISTANCE);
      2: return 10'($urandom_range(0, 1023));
      default: return 10'(wcsm_pkg::FULL_BLOCK_DISTANCE);
    endcase
  endfunction

  task automatic random_move(int ticks);
    logic [11:0] front;
    send_item(1'b0, pick_distance(), 8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
              12'($urandom_range(0, 4095)), 13'($urandom_range(0, 5759)), 20'($urandom));
    for (int i = 0; i < ticks; i++) begin
      front = ($urandom_range(0, 19) == 0) ? 12'($urandom_range(0, 100))
              : 12'($urandom_range(100, 4095));
      send_item(1'b1, 10'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                : 8'($urandom_range(0, 14)), $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                : 8'($urandom_range(0, 14)), front,
                ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
                : 13'($urandom_range(0, 5759)),
                ($urandom_range(0, 9) == 0) ? 20'($urandom_range(0, 1048575))
                : 20'($urandom_range(0, 40000)));
    end
  endtask

  task automatic random_phase(int moves);
    for (int m = 0; m < moves; m++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(1'b1, 10'($urandom), 8'($urandom), 8'($urandom), 12'($urandom), 13'($urandom),
                  20'($urandom));
      random_move($urandom_range(2, 30));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part with reset configuration: idle tick, heading ties and
    // wrap, out of range heading, zero tick, front stop, time stop, creep.
    send_item(1, 0, 0, 0, 4095, 0, 0);
    send_item(0, wcsm_pkg::FULL_BLOCK_DISTANCE, 2, 6, 4095, 360, 0);
    send_item(1, 0, 0, 255, 4095, 5759, 0);
    send_item(1, 1023, 255, 0, 4095, 8191, 1048575);
    send_item(1, 0, 255, 255, 4095, 1080, 1);
    send_item(1, 0, 3, 3, 4095, 0, 1000);
    send_item(1, 0, 0, 0, 0, 0, 1000);
    send_item(1, 0, 0, 0, 4095, 0, 1000);
    send_item(0, wcsm_pkg::HALF_BLOCK_DISTANCE, 255, 255, 0, 5400, 1);
    send_item(1, 0, 7, 255, 59, 2880, 0);
    send_item(0, 1023, 0, 7, 0, 3240, 0);
    send_item(1, 0, 4, 0, 4095, 6000, 1048575);
    send_item(1, 0, 4, 0, 4095, 0, 5);
    send_item(0, wcsm_pkg::FULL_BLOCK_DISTANCE, 0, 0, 60, 2520, 0);
    send_item(0, wcsm_pkg::FULL_BLOCK_DISTANCE, 1, 255, 60, 4680, 1000);
    send_item(1, 0, 0, 255, 60, 4680, 700000);
    send_item(1, 0, 0, 255, 60, 4680, 1000);
    send_item(1, 0, 0, 255, 60, 4680, 1000);
    settle();

    // Extreme settings: fastest runs with largest gains.
    write_reg(wcsm_pkg::REG_BASE_RUN, 20'd1);
    write_reg(wcsm_pkg::REG_BASE_SPEED, 20'd255);
    write_reg(wcsm_pkg::REG_GAIN_P, 20'd4095);
    write_reg(wcsm_pkg::REG_GAIN_TD, 20'd4095);
    write_reg(wcsm_pkg::REG_GAIN_H, 20'd4095);
    write_reg(wcsm_pkg::REG_FRONT_STOP, 20'd0);
    write_reg(wcsm_pkg::REG_WALL_THRESH, 20'd255);
    write_reg(wcsm_pkg::REG_TARGET_WALL, 20'd255);
    random_phase(16);
    settle();

    // Zero gains and speed, a long run, and a stall of the result side.
    write_reg(wcsm_pkg::REG_BASE_RUN, 20'd1000000);
    write_reg(wcsm_pkg::REG_BASE_SPEED, 20'd0);
    write_reg(wcsm_pkg::REG_GAIN_P, 20'd0);
    write_reg(wcsm_pkg::REG_GAIN_TD, 20'd0);
    write_reg(wcsm_pkg::REG_GAIN_H, 20'd0);
    write_reg(wcsm_pkg::REG_FRONT_STOP, 20'd4095);
    write_reg(wcsm_pkg::REG_WALL_THRESH, 20'd0);
    write_reg(wcsm_pkg::REG_TARGET_WALL, 20'd0);
    hold_off = 1;
    random_phase(12);
    settle();

    for (int p = 0; p < 4; p++) begin
      write_reg(wcsm_pkg::REG_BASE_RUN, 20'($urandom_range(1000, 60000)));
      write_reg(wcsm_pkg::REG_BASE_SPEED, 20'($urandom_range(0, 255)));
      write_reg(wcsm_pkg::REG_GAIN_P, 20'($urandom_range(0, 4095)));
      write_reg(wcsm_pkg::REG_GAIN_TD, 20'($urandom_range(0, 4095)));
      write_reg(wcsm_pkg::REG_GAIN_H, 20'($urandom_range(0, 4095)));
      write_reg(wcsm_pkg::REG_FRONT_STOP, 20'($urandom_range(0, 200)));
      write_reg(wcsm_pkg::REG_WALL_THRESH, 20'($urandom_range(4, 16)));
      write_reg(wcsm_pkg::REG_TARGET_WALL, 20'($urandom_range(0, 8)));
      random_phase(11);
      settle();
    end

    in_chan.valid <= 0;
    stimulus_done = 1;
  end

  initial begin
    wait (stimulus_done);
    wait (pending == 0);
    repeat (300) @(posedge clk);
    $display("sent %0d items, checked %0d results, %0d of them move stops",
             sent, results_seen, stops_seen);
    if (fail_count == 0 && pending == 0)
      $display("wall_centering_straight_move regression: pass");
    else
      $display("wall_centering_straight_move regression: fail");
    $finish;
  end
endmodule
